>>> design/imufs_pkg.sv
// imufs_pkg: shared types and constants of the imu frame sync parser
// used by imufs_check, imu_frame_sync_parser and imufs_checker; no dependencies
`timescale 1ns / 1ps

package imufs_pkg;

  // frame layout
  localparam int unsigned FRAME_LEN = 11;
  localparam int unsigned HIST_LEN  = FRAME_LEN - 1;
  localparam logic [3:0]  FILL_FULL = 4'(FRAME_LEN);

  // register map: index taken from paddr[3:2]
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_HEADER = 2'd0;
  localparam logic [1:0] REG_RATE   = 2'd1;
  localparam logic [1:0] REG_ANGLE  = 2'd2;

  // register reset values
  localparam logic [7:0] HEADER_RST = 8'h55;
  localparam logic [7:0] RATE_RST   = 8'h52;
  localparam logic [7:0] ANGLE_RST  = 8'h53;

  // frame kind codes
  localparam logic KIND_RATE  = 1'b0;
  localparam logic KIND_ANGLE = 1'b1;

  typedef logic [7:0] byte_t;

  // configuration seen by the checker
  typedef struct packed {
    byte_t header_code;
    byte_t rate_type_code;
    byte_t angle_type_code;
  } cfg_t;

  // one decoded frame
  typedef struct packed {
    logic               frame_kind;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } result_t;

  // verdict on the candidate frame
  typedef struct packed {
    logic match;  // header and checksum good, frame consumed
    logic emit;   // known type, a result beat follows
  } verdict_t;

endpackage

>>> design/imufs_check.sv
// imufs_check: header, checksum and type test of one candidate frame
// depends on imufs_pkg
`timescale 1ns / 1ps

module imufs_check import imufs_pkg::*; (
  input  byte_t    hist [HIST_LEN],
  input  byte_t    newest,
  input  logic     full,
  input  cfg_t     cfg,
  output verdict_t verdict,
  output result_t  result
);

  logic [7:0] sum_a;
  logic [7:0] sum_b;
  logic [7:0] sum;
  byte_t      type_byte;
  logic       is_rate;
  logic       is_angle;

  // modulo-256 checksum over the ten oldest bytes, as a shallow tree
  assign sum_a = (hist[0] + hist[1]) + (hist[2] + hist[3]) + hist[4];
  assign sum_b = (hist[5] + hist[6]) + (hist[7] + hist[8]) + hist[9];
  assign sum   = sum_a + sum_b;

  // type decode, rate wins when both codes are equal
  assign type_byte = hist[1];
  assign is_rate   = (type_byte == cfg.rate_type_code);
  assign is_angle  = (type_byte == cfg.angle_type_code);

  assign verdict.match = full && (hist[0] == cfg.header_code) && (sum == newest);
  assign verdict.emit  = verdict.match && (is_rate || is_angle);

  // little-endian axes
  assign result.frame_kind = is_rate ? KIND_RATE : KIND_ANGLE;
  assign result.axis_x     = {hist[3], hist[2]};
  assign result.axis_y     = {hist[5], hist[4]};
  assign result.axis_z     = {hist[7], hist[6]};

endmodule

>>> design/imu_frame_sync_parser.sv
// imu_frame_sync_parser: top level of the imu serial frame parser
// depends on imufs_pkg and imufs_check
`timescale 1ns / 1ps

// Usage
//   Input channel: one serial byte per beat (data_byte, chunk_end) with
//   in_valid / in_stall. A byte is taken at each edge with in_valid high and
//   in_stall low; one byte per cycle is sustained while in_stall stays low.
//   Output channel: one beat per decoded rate or angle frame (frame_kind,
//   axis_x, axis_y, axis_z) with out_valid / out_stall.
//   Result: a frame's result is registered at the edge that takes its
//   checksum byte, into the skid register if the result register is busy. The
//   ten previous bytes sit in a shift line; the eleventh is checked on the fly.
//   Stall: a two-entry output stage (result register plus skid register)
//   keeps bytes flowing while a result waits; in_stall rises only when
//   both entries hold a result.
//   Reset (rst, synchronous): clears the fill count and both output
//   entries and loads the default header 0x55, rate 0x52 and angle 0x53.
//   Configuration: APB-style, registers at byte address 0, 4 and 8, pready
//   always high; the user writes them only while idle, unchecked by the block.

module imu_frame_sync_parser import imufs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // byte input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                chunk_end,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                frame_kind,
  output logic signed [15:0]  axis_x,
  output logic signed [15:0]  axis_y,
  output logic signed [15:0]  axis_z,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t       cfg;
  byte_t      hist [HIST_LEN];
  logic [3:0] fill;
  logic [3:0] fill_inc;
  logic [3:0] fill_next;
  logic       take_in;
  logic       take_out;
  verdict_t   verdict;
  result_t    cand;
  result_t    out_res;
  result_t    skid_res;
  logic       skid_valid;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_code     <= HEADER_RST;
      cfg.rate_type_code  <= RATE_RST;
      cfg.angle_type_code <= ANGLE_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_HEADER: cfg.header_code     <= pwdata[7:0];
        REG_RATE:   cfg.rate_type_code  <= pwdata[7:0];
        REG_ANGLE:  cfg.angle_type_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_HEADER: prdata = {24'd0, cfg.header_code};
      REG_RATE:   prdata = {24'd0, cfg.rate_type_code};
      REG_ANGLE:  prdata = {24'd0, cfg.angle_type_code};
      default:    prdata = 32'd0;
    endcase
  end

  // handshakes
  assign in_stall = skid_valid;
  assign take_in  = in_valid && !skid_valid;
  assign take_out = out_valid && !out_stall;

  // frame test on the stored bytes plus the incoming one
  assign fill_inc = (fill < FILL_FULL) ? fill + 4'd1 : FILL_FULL;

  imufs_check u_check (
    .hist    (hist),
    .newest  (data_byte),
    .full    (fill_inc == FILL_FULL),
    .cfg     (cfg),
    .verdict (verdict),
    .result  (cand)
  );

  // fill count: cleared by a consumed frame or a chunk end
  always_comb begin
    fill_next = fill_inc;
    if (verdict.match || chunk_end) begin
      fill_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 4'd0;
    end else if (take_in) begin
      fill <= fill_next;
    end
  end

  // byte history shift line, entry 0 oldest
  always_ff @(posedge clk) begin
    if (take_in) begin
      for (int i = 0; i < HIST_LEN - 1; i++) begin
        hist[i] <= hist[i+1];
      end
      hist[HIST_LEN-1] <= data_byte;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take_out) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (take_in && verdict.emit) begin
      if (!out_valid || take_out) begin
        out_res   <= cand;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= cand;
        skid_valid <= 1'b1;
      end
    end else if (take_out) begin
      out_valid <= 1'b0;
    end
  end

  assign frame_kind = out_res.frame_kind;
  assign axis_x     = out_res.axis_x;
  assign axis_y     = out_res.axis_y;
  assign axis_z     = out_res.axis_z;

endmodule

>>> design/imufs_checker.sv
// imufs_checker: port-level assertions for imu_frame_sync_parser, with bind
// depends on imufs_pkg
`timescale 1ns / 1ps

module imufs_checker import imufs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               frame_kind,
  input logic signed [15:0] axis_x,
  input logic signed [15:0] axis_y,
  input logic signed [15:0] axis_z,
  input logic               pready
);

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output stage not empty after reset");

  // input backpressure only when a result is already waiting
  a_stall_backlog: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall high with no pending result");

  // taken result with no backlog and no new byte leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !in_stall && !in_valid |=> !out_valid)
    else $error("result beat repeated");

  // stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_kind) && $stable(axis_x)
      && $stable(axis_y) && $stable(axis_z))
    else $error("stalled result changed");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind imu_frame_sync_parser imufs_checker u_imufs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .frame_kind (frame_kind),
  .axis_x     (axis_x),
  .axis_y     (axis_y),
  .axis_z     (axis_z),
  .pready     (pready)
);

>>> sim/tb.sv
// tb: self-checking bench for imu_frame_sync_parser, serial bytes in, decoded frames out
// depends on imufs_pkg and the imu_frame_sync_parser rtl
// a bit-true frame decoder runs on every accepted byte and frames are matched in order
`timescale 1ns / 1ps

module tb;
  import imufs_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped index, writes must be dropped
  localparam int LAST_POS  = FRAME_LEN - 1;
  localparam int NO_CUT    = -1;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG  = 4000;

  typedef struct packed {
    byte_t value;
    logic  last;
  } serial_beat_t;

  // dut ports
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = 8'h00;
  logic               chunk_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               frame_kind;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [ADDR_W-1:0]  paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  // decoder copy of the block state
  cfg_t       cfg;
  byte_t      win [FRAME_LEN];
  logic [3:0] fill_cnt;

  // traffic bookkeeping
  serial_beat_t tx_bytes [$];
  result_t      frames_due [$];
  int  queued_total    = 0;
  int  sent_total      = 0;
  int  err_count       = 0;
  int  quiet_cycles    = 0;
  bit  in_fire         = 1'b0;
  bit  idle_on         = 1'b0;
  bit  src_pause       = 1'b0;
  int  src_gap         = 0;
  int  rx_gap          = 0;
  int  hold_left       = 0;
  int  long_holds_req  = 0;
  int  long_holds_done = 0;

  imu_frame_sync_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .chunk_end  (chunk_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_kind (frame_kind),
    .axis_x     (axis_x),
    .axis_y     (axis_y),
    .axis_z     (axis_z),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shift in one byte, check the window, queue a frame when one decodes
  task automatic decode_byte(input byte_t b, input logic last);
    byte_t   sum;
    result_t r;
    for (int k = 0; k < LAST_POS; k++) win[k] = win[k+1];
    win[LAST_POS] = b;
    if (fill_cnt < FILL_FULL) fill_cnt++;
    if (fill_cnt == FILL_FULL && win[0] == cfg.header_code) begin
      sum = 8'h00;
      for (int k = 0; k < LAST_POS; k++) sum += win[k];
      if (sum == win[LAST_POS]) begin
        // rate code wins when both codes are equal
        if (win[1] == cfg.rate_type_code || win[1] == cfg.angle_type_code) begin
          r.frame_kind = (win[1] == cfg.rate_type_code) ? KIND_RATE : KIND_ANGLE;
          r.axis_x     = {win[3], win[2]};
          r.axis_y     = {win[5], win[4]};
          r.axis_z     = {win[7], win[6]};
          frames_due.push_back(r);
        end
        fill_cnt = '0;
      end
    end
    if (last) fill_cnt = '0;
  endtask

  function automatic void flag_field(input string what, input logic signed [16:0] want,
                                     input logic signed [16:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // input and output beats, decoder and watchdog
  always @(posedge clk) begin : watch_ports
    result_t want;
    in_fire = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_fire = 1'b1;
        sent_total++;
        decode_byte(data_byte, chunk_end);
      end
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected frame, expected none, got kind %0d x %0d y %0d z %0d",
                   $time, frame_kind, axis_x, axis_y, axis_z);
        end else begin
          want = frames_due.pop_front();
          flag_field("frame_kind", want.frame_kind, frame_kind);
          flag_field("axis_x", want.axis_x, axis_x);
          flag_field("axis_y", want.axis_y, axis_y);
          flag_field("axis_z", want.axis_z, axis_z);
        end
      end
      if (in_fire || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // byte driver with random gaps
  always @(negedge clk) begin : drive_bytes
    logic         nv;
    serial_beat_t nb;
    nv       = in_valid;
    nb.value = data_byte;
    nb.last  = chunk_end;
    if (!rst) begin
      if (in_valid && in_fire) begin
        nv = 1'b0;
        if (idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 7);
      end
      if (!nv) begin
        if (src_gap > 0) src_gap--;
        else if (!src_pause && tx_bytes.size() > 0) begin
          nb = tx_bytes.pop_front();
          nv = 1'b1;
        end
      end
    end
    in_valid  <= nv;
    data_byte <= nb.value;
    chunk_end <= nb.last;
  end

  // result receiver: random stall bursts plus one long hold on request
  always @(negedge clk) begin : drive_stall
    logic st;
    if (long_holds_done != long_holds_req) begin
      hold_left = LONG_HOLD;
      long_holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      st = 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      st = 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 6);
      st = 1'b1;
    end else begin
      st = 1'b0;
    end
    out_stall <= st;
  end

  // apb write: setup then access, upper data bits are junk
  task automatic write_reg(input logic [1:0] idx, input byte_t val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= {24'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HEADER: cfg.header_code     = val;
      REG_RATE:   cfg.rate_type_code  = val;
      REG_ANGLE:  cfg.angle_type_code = val;
      default: ;
    endcase
  endtask

  task automatic push_byte(input byte_t b, input logic last);
    serial_beat_t nb;
    nb.value = b;
    nb.last  = last;
    tx_bytes.push_back(nb);
    queued_total++;
  endtask

  // one frame, checksum offset by sum_err, chunk_end on byte cut_at
  task automatic push_frame(input byte_t hdr, input byte_t typ, input logic [15:0] x,
                            input logic [15:0] y, input logic [15:0] z,
                            input byte_t sum_err, input int cut_at);
    byte_t f [FRAME_LEN];
    byte_t sum;
    f[0] = hdr;
    f[1] = typ;
    f[2] = x[7:0];
    f[3] = x[15:8];
    f[4] = y[7:0];
    f[5] = y[15:8];
    f[6] = z[7:0];
    f[7] = z[15:8];
    f[8] = 8'($urandom);
    f[9] = 8'($urandom);
    sum  = 8'h00;
    for (int k = 0; k < LAST_POS; k++) sum += f[k];
    f[LAST_POS] = sum + sum_err;
    for (int k = 0; k < FRAME_LEN; k++) push_byte(f[k], k == cut_at);
  endtask

  // random bytes; close ends them as a short chunk
  task automatic push_noise(input int n, input bit close);
    for (int k = 0; k < n; k++) begin
      if (close) push_byte(8'($urandom), k == n - 1);
      else push_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  function automatic logic [15:0] axis_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly good frames with random content, the rest broken frames and noise
  task automatic mix_traffic(input int n);
    int    stop;
    int    r;
    byte_t t;
    stop = queued_total + n;
    while (queued_total < stop) begin
      r = $urandom_range(0, 99);
      t = $urandom_range(0, 1) ? cfg.rate_type_code : cfg.angle_type_code;
      if (r < 55) begin
        push_frame(cfg.header_code, t, axis_value(), axis_value(), axis_value(), 8'h00,
                   ($urandom_range(0, 3) == 0) ? LAST_POS : NO_CUT);
      end else if (r < 65) begin
        // unknown type: consumed silently
        do t = 8'($urandom);
        while (t == cfg.rate_type_code || t == cfg.angle_type_code);
        push_frame(cfg.header_code, t, axis_value(), axis_value(), axis_value(), 8'h00,
                   NO_CUT);
      end else if (r < 75) begin
        push_frame(cfg.header_code, t, axis_value(), axis_value(), axis_value(),
                   8'($urandom_range(1, 255)), NO_CUT);
      end else if (r < 82) begin
        push_frame(cfg.header_code ^ 8'($urandom_range(1, 255)), t, axis_value(),
                   axis_value(), axis_value(), 8'h00, NO_CUT);
      end else if (r < 90) begin
        push_noise($urandom_range(1, 5), 1'b0);
      end else if (r < 95) begin
        // chunk boundary inside the frame
        push_frame(cfg.header_code, t, axis_value(), axis_value(), axis_value(), 8'h00,
                   $urandom_range(0, LAST_POS - 1));
      end else begin
        push_noise($urandom_range(1, LAST_POS), 1'b1);
      end
    end
  endtask

  task automatic wait_drained(input int extra);
    while (sent_total != queued_total || frames_due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // reprogram while idle, then run random traffic
  task automatic run_phase(input byte_t hdr, input byte_t rate, input byte_t angle,
                           input int n, input bit idle);
    wait_drained(4);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_RATE, rate);
    write_reg(REG_ANGLE, angle);
    write_reg(REG_SPARE, 8'($urandom));
    @(posedge clk);
    idle_on = idle;
    mix_traffic(n);
  endtask

  initial begin : run
    byte_t same_code;
    cfg      = '{HEADER_RST, RATE_RST, ANGLE_RST};
    fill_cnt = '0;
    foreach (win[k]) win[k] = 8'h00;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme axes, short chunk, frame closing a chunk
    push_frame(HEADER_RST, RATE_RST, 16'h8000, 16'h7fff, 16'hffff, 8'h00, NO_CUT);
    push_byte(HEADER_RST, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b1);
    push_frame(HEADER_RST, ANGLE_RST, 16'h0000, 16'h0001, 16'h8000, 8'h00, LAST_POS);
    idle_on = 1'b1;
    mix_traffic(230);

    run_phase(8'h00, 8'hff, 8'h01, 230, 1'b1);
    run_phase(8'hff, 8'h00, 8'hff, 230, 1'b0);
    same_code = 8'($urandom);
    run_phase(8'($urandom), same_code, same_code, 230, 1'b1);

    // output backpressure: long hold while good frames keep coming
    run_phase(8'($urandom), 8'($urandom), 8'($urandom), 0, 1'b0);
    for (int k = 0; k < 30; k++)
      push_frame(cfg.header_code,
                 $urandom_range(0, 1) ? cfg.rate_type_code : cfg.angle_type_code,
                 axis_value(), axis_value(), axis_value(), 8'h00, NO_CUT);
    long_holds_req++;
    @(posedge clk);
    while (long_holds_done != long_holds_req || hold_left > 0) @(posedge clk);

    // sender pause until every pending frame is out
    src_pause = 1'b1;
    @(negedge clk);
    while (in_valid || frames_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    @(posedge clk);
    src_pause = 1'b0;
    idle_on   = 1'b1;
    mix_traffic(100);

    // closing stretch at full rate
    run_phase(HEADER_RST, RATE_RST, ANGLE_RST, 160, 1'b0);

    wait_drained(10);
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
